// ===== sv/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
// Used by ptd_ctrl, ptd_datapath and periodic_task_dispatcher_top.
package ptd_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam logic [15:0] WAIT_CAP_RST = 16'd200;

  localparam int REQ_W     = 3;
  localparam int SLOT_IN_W = 8;
  localparam int IV_W      = 16;
  localparam int CD_W      = 32;
  localparam int KIND_W    = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CREATE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHANGE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd5;

  typedef struct packed {
    logic latch;      // capture request fields
    logic idx_hint;   // scan index <= free hint
    logic idx_zero;   // scan index <= 0
    logic crt_step;   // one create search step
    logic del_exec;
    logic clr_exec;
    logic chg_rd;     // read slot entry for change
    logic chg_wr;
    logic tick_rd;    // issue tick read at scan index
    logic tick_done;
  } ptd_cmd_t;

  typedef struct packed {
    logic crt_end;    // create search finishes this cycle
    logic idx_last;   // scan index at the last slot
  } ptd_stat_t;

endpackage

// ===== sv/periodic_task_dispatcher_top.sv =====
// Periodic task dispatcher: top level with the wait_cap register on an APB port.
// Instantiates ptd_ctrl and ptd_datapath; depends on ptd_pkg.
//
//   channel   handshake            payload
//   in_       start / busy         in_req_type, in_slot, in_interval, in_elapsed
//   out_      out_strobe (1 cyc)   out_kind, out_task_slot, out_ok, out_next_wait,
//                                  out_active_count, out_last
//   config    psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// A beat is taken when start is high and busy low. The result beat is registered and
// appears in the cycle after the work. Change reads the table entry, then writes it;
// create searches for a free slot from the hint, one slot per cycle. A tick walks the
// slot memory one entry per cycle through its registered read port, with up to one
// dispatch beat per slot, then tick done.
// Reset (synchronous rst_n) empties the table and sets wait_cap to 200.
// Results cannot be stalled; each strobe is a single cycle.
module periodic_task_dispatcher_top #(
  parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptd_pkg::REQ_W-1:0]           in_req_type,
  input  logic [ptd_pkg::SLOT_IN_W-1:0]       in_slot,
  input  logic [ptd_pkg::IV_W-1:0]            in_interval,
  input  logic [ptd_pkg::IV_W-1:0]            in_elapsed,
  output logic                                out_strobe,
  output logic [ptd_pkg::KIND_W-1:0]          out_kind,
  output logic [$clog2(NUM_SLOTS)-1:0]        out_task_slot,
  output logic                                out_ok,
  output logic signed [ptd_pkg::CD_W-1:0]     out_next_wait,
  output logic [$clog2(NUM_SLOTS+1)-1:0]      out_active_count,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ptd_pkg::*;

  localparam int CW = $clog2(NUM_SLOTS + 1);

  ptd_cmd_t  cmd;
  ptd_stat_t stat;
  logic [IV_W-1:0] wait_cap_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_cap_r <= WAIT_CAP_RST;
    end else if (cfg_wr) begin
      wait_cap_r <= pwdata[IV_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-IV_W){1'b0}}, wait_cap_r};

  ptd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  ptd_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_slot          (in_slot),
    .in_interval      (in_interval),
    .in_elapsed       (in_elapsed),
    .wait_cap         (wait_cap_r),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_task_slot    (out_task_slot),
    .out_ok           (out_ok),
    .out_next_wait    (out_next_wait),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  a_disp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_DISPATCH) |-> !out_last)
    else $error("dispatch beat flagged as last");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind != KIND_DISPATCH) |-> out_last)
    else $error("closing beat missing last flag");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_active_count <= CW'(NUM_SLOTS))
    else $error("occupied count above slot count");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_TICK) |=> (busy && !out_strobe))
    else $error("tick not taken up by the sequencer");
`endif

endmodule

// ===== sv/ptd_ctrl.sv =====
// Sequencer for the periodic task dispatcher.
// Decodes requests and drives ptd_datapath; depends on ptd_pkg.
module ptd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ptd_pkg::REQ_W-1:0]      in_req_type,
  input  ptd_pkg::ptd_stat_t             stat,
  output ptd_pkg::ptd_cmd_t              cmd,
  output logic                           busy
);
  import ptd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CREATE,
    ST_DELETE,
    ST_CHG_RD,
    ST_CHG_WR,
    ST_TICK,
    ST_DRAIN,
    ST_TDONE,
    ST_CLEAR
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (in_req_type)
            REQ_CREATE: begin
              cmd.idx_hint = 1'b1;
              state_nxt    = ST_CREATE;
            end
            REQ_DELETE: state_nxt = ST_DELETE;
            REQ_CHANGE: state_nxt = ST_CHG_RD;
            REQ_TICK: begin
              cmd.idx_zero = 1'b1;
              state_nxt    = ST_TICK;
            end
            REQ_CLEAR:  state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CREATE: begin
        cmd.crt_step = 1'b1;
        if (stat.crt_end) state_nxt = ST_IDLE;
      end
      ST_DELETE: begin
        cmd.del_exec = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CHG_RD: begin
        cmd.chg_rd = 1'b1;
        state_nxt  = ST_CHG_WR;
      end
      ST_CHG_WR: begin
        cmd.chg_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_TICK: begin
        cmd.tick_rd = 1'b1;
        if (stat.idx_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_TDONE;  // last slot retires here
      ST_TDONE: begin
        cmd.tick_done = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clr_exec = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/ptd_datapath.sv =====
// Slot table, interval/countdown memory and result register.
// Driven by ptd_ctrl through ptd_cmd_t; depends on ptd_pkg.
module ptd_datapath #(
  parameter int NUM_SLOTS = ptd_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptd_pkg::ptd_cmd_t                   cmd,
  output ptd_pkg::ptd_stat_t                  stat,
  input  logic [ptd_pkg::SLOT_IN_W-1:0]       in_slot,
  input  logic [ptd_pkg::IV_W-1:0]            in_interval,
  input  logic [ptd_pkg::IV_W-1:0]            in_elapsed,
  input  logic [ptd_pkg::IV_W-1:0]            wait_cap,
  output logic                                out_strobe,
  output logic [ptd_pkg::KIND_W-1:0]          out_kind,
  output logic [$clog2(NUM_SLOTS)-1:0]        out_task_slot,
  output logic                                out_ok,
  output logic signed [ptd_pkg::CD_W-1:0]     out_next_wait,
  output logic [$clog2(NUM_SLOTS+1)-1:0]      out_active_count,
  output logic                                out_last
);
  import ptd_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int MW = IV_W + CD_W;
  localparam logic [CW-1:0] FULL     = CW'(NUM_SLOTS);
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SLOTS - 1);

  logic [NUM_SLOTS-1:0] valid_r;
  logic [CW-1:0]        count_r, hint_r, idx_r;
  logic [SLOT_IN_W-1:0] slot_r;
  logic [IV_W-1:0]      iv_r, el_r;
  logic signed [CD_W-1:0] wait_r;
  logic                 stop_r;
  logic                 p_vld_r;
  logic [SW-1:0]        p_idx_r;

  // entry = {interval, countdown}
  logic [MW-1:0] mem [NUM_SLOTS];
  logic [MW-1:0] rd_data_r;
  logic [SW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;
  logic          wr_en;

  logic          out_strobe_r, out_ok_r, out_last_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SW-1:0] out_slot_r;
  logic signed [CD_W-1:0] out_wait_r;

  logic [SW-1:0] slot_idx, idx_sel;
  logic          slot_hit, tbl_full, idx_end, crt_found;
  logic signed [CD_W-1:0] rd_cd, iv_ext, chg_cd, new_cd;
  logic [IV_W-1:0] rd_iv;
  logic [CD_W:0] diff, ivel, rel;
  logic          sat, el_nz, dispatch, p_hit, t_lt, t_le0;

  logic          em_valid, em_ok, em_last;
  logic [KIND_W-1:0] em_kind;
  logic [SW-1:0] em_slot;
  logic signed [CD_W-1:0] em_wait;

  assign slot_idx  = slot_r[SW-1:0];
  assign idx_sel   = idx_r[SW-1:0];
  assign slot_hit  = (slot_r < SLOT_IN_W'(NUM_SLOTS)) && valid_r[slot_idx];
  assign tbl_full  = (count_r == FULL);
  assign idx_end   = (idx_r == FULL);
  assign crt_found = !tbl_full && !idx_end && !valid_r[idx_sel];

  assign stat.crt_end  = tbl_full || idx_end || !valid_r[idx_sel];
  assign stat.idx_last = (idx_r == LAST_IDX);

  assign rd_cd  = signed'(rd_data_r[CD_W-1:0]);
  assign rd_iv  = rd_data_r[MW-1:CD_W];
  assign iv_ext = signed'({{(CD_W-IV_W){1'b0}}, iv_r});
  assign chg_cd = (iv_ext < rd_cd) ? iv_ext : rd_cd;

  // countdown - elapsed, and the reloaded value, side by side
  assign el_nz = (el_r != '0);
  assign diff  = {rd_cd[CD_W-1], rd_cd} - {{(CD_W+1-IV_W){1'b0}}, el_r};
  assign ivel  = {{(CD_W+1-IV_W){1'b0}}, rd_iv} - {{(CD_W+1-IV_W){1'b0}}, el_r};
  assign rel   = {rd_cd[CD_W-1], rd_cd} + ivel;
  assign sat   = diff[CD_W] & ~diff[CD_W-1];

  always_comb begin
    if (!el_nz) begin
      new_cd = rd_cd;
    end else if (sat) begin
      new_cd = signed'({1'b1, {(CD_W-1-IV_W){1'b0}}, rd_iv});  // floor plus interval
    end else if (diff[CD_W]) begin
      new_cd = signed'(rel[CD_W-1:0]);
    end else begin
      new_cd = signed'(diff[CD_W-1:0]);
    end
  end

  assign dispatch = el_nz && diff[CD_W];
  assign p_hit    = p_vld_r && valid_r[p_idx_r];
  assign t_lt     = (new_cd < wait_r);
  assign t_le0    = new_cd[CD_W-1] || (new_cd == '0);

  assign rd_addr = cmd.chg_rd ? slot_idx : idx_sel;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx_r;
    wr_data = {rd_iv, new_cd};
    if (cmd.crt_step && crt_found) begin
      wr_en   = 1'b1;
      wr_addr = idx_sel;
      wr_data = {iv_r, iv_ext};
    end else if (cmd.chg_wr && slot_hit) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx;
      wr_data = {iv_r, chg_cd};
    end else if (p_hit && el_nz) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    em_valid = 1'b0;
    em_kind  = KIND_CREATE;
    em_slot  = '0;
    em_ok    = 1'b1;
    em_wait  = '0;
    em_last  = 1'b1;
    if (cmd.crt_step && stat.crt_end) begin
      em_valid = 1'b1;
      em_slot  = crt_found ? idx_sel : '0;
      em_ok    = crt_found;
    end else if (cmd.del_exec) begin
      em_valid = 1'b1;
      em_kind  = KIND_DELETE;
      em_ok    = slot_hit;
    end else if (cmd.chg_wr) begin
      em_valid = 1'b1;
      em_kind  = KIND_CHANGE;
      em_ok    = slot_hit;
    end else if (cmd.clr_exec) begin
      em_valid = 1'b1;
      em_kind  = KIND_CLEARED;
    end else if (cmd.tick_done) begin
      em_valid = 1'b1;
      em_kind  = KIND_TICK_DONE;
      em_wait  = wait_r;
    end else if (p_hit && dispatch) begin
      em_valid = 1'b1;
      em_kind  = KIND_DISPATCH;
      em_slot  = p_idx_r;
      em_last  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      hint_r       <= '0;
      p_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      p_vld_r      <= cmd.tick_rd;
      out_strobe_r <= em_valid;
      if (cmd.crt_step && crt_found) begin
        valid_r[idx_sel] <= 1'b1;
        count_r          <= count_r + 1'b1;
        hint_r           <= idx_r + 1'b1;
      end
      if (cmd.del_exec && slot_hit) begin
        valid_r[slot_idx] <= 1'b0;
        count_r           <= count_r - 1'b1;
        if (CW'(slot_idx) < hint_r) hint_r <= CW'(slot_idx);
      end
      if (cmd.clr_exec) begin
        valid_r <= '0;
        count_r <= '0;
        hint_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      slot_r <= in_slot;
      iv_r   <= (in_interval == '0) ? IV_W'(1) : in_interval;
      el_r   <= in_elapsed;
      wait_r <= signed'({{(CD_W-IV_W){1'b0}}, wait_cap});
      stop_r <= 1'b0;
    end else if (p_hit && !stop_r) begin
      // next wait: running minimum, frozen at the first non-positive countdown
      if (t_lt)  wait_r <= new_cd;
      if (t_le0) stop_r <= 1'b1;
    end
    if (cmd.idx_hint) begin
      idx_r <= hint_r;
    end else if (cmd.idx_zero) begin
      idx_r <= '0;
    end else if (cmd.tick_rd || (cmd.crt_step && !stat.crt_end)) begin
      idx_r <= idx_r + 1'b1;
    end
    p_idx_r    <= idx_sel;
    out_kind_r <= em_kind;
    out_slot_r <= em_slot;
    out_ok_r   <= em_ok;
    out_wait_r <= em_wait;
    out_last_r <= em_last;
  end

  assign out_strobe       = out_strobe_r;
  assign out_kind         = out_kind_r;
  assign out_task_slot    = out_slot_r;
  assign out_ok           = out_ok_r;
  assign out_next_wait    = out_wait_r;
  assign out_active_count = count_r;
  assign out_last         = out_last_r;

endmodule

// ===== tb/sv/periodic_task_dispatcher_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for periodic_task_dispatcher_top: directed and random requests,
// APB writes of wait_cap between phases, scoreboard class predicting every result beat.
// Depends on ptd_pkg and the periodic_task_dispatcher_top RTL.
module periodic_task_dispatcher_top_tb;
  import ptd_pkg::*;

  localparam int NSLOT = NUM_SLOTS_DEF;
  localparam int DRAIN_CYCLES = NSLOT + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] WAIT_CAP_ADDR = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST = 3'd7;
  localparam longint CD_FLOOR = -64'sd2147483648;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_IN_W-1:0] slot;
    logic [IV_W-1:0]      interval;
    logic [IV_W-1:0]      elapsed;
  } sched_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [3:0]             task_slot;
    logic                   ok;
    logic signed [CD_W-1:0] next_wait;
    logic [4:0]             active_count;
    logic                   last;
  } sched_result_t;

  // Mirror of the slot table; predicts the result beats of each accepted request.
  class dispatch_scoreboard;
    bit               slot_used[NSLOT];
    bit               ever_written[NSLOT];
    logic [IV_W-1:0]  reload[NSLOT];
    int               countdown[NSLOT];
    int unsigned      occupied;
    int unsigned      free_hint;
    logic [15:0]      wait_cap;
    sched_result_t    due_results[$];
    int               errors;
    int               checked;
    int               dispatches;

    function void clear_table();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      occupied = 0;
      free_hint = 0;
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, int tslot, bit ok, int wait_val,
                              bit last);
      sched_result_t r;
      r.kind = kind;
      r.task_slot = 4'(tslot);
      r.ok = ok;
      r.next_wait = wait_val;
      r.active_count = 5'(occupied);
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void note_request(sched_req_t q);
      logic [IV_W-1:0] ivl;
      int found;
      longint diff;
      int wait_val;
      bit ok;
      ivl = (q.interval == 0) ? 16'd1 : q.interval;
      ok = 1'b0;
      case (q.req_type)
        REQ_CREATE: begin
          found = NSLOT;
          if (occupied < NSLOT) begin
            for (int i = free_hint; i < NSLOT; i++) begin
              if (!slot_used[i]) begin
                found = i;
                break;
              end
            end
          end
          if (found < NSLOT) begin
            slot_used[found] = 1'b1;
            ever_written[found] = 1'b1;
            reload[found] = ivl;
            countdown[found] = int'(ivl);
            occupied++;
            free_hint = found + 1;
            push_result(KIND_CREATE, found, 1'b1, 0, 1'b1);
          end else begin
            push_result(KIND_CREATE, 0, 1'b0, 0, 1'b1);
          end
        end
        REQ_DELETE: begin
          if (q.slot < NSLOT && slot_used[q.slot]) begin
            slot_used[q.slot] = 1'b0;
            occupied--;
            if (q.slot < free_hint) free_hint = q.slot;
            ok = 1'b1;
          end
          push_result(KIND_DELETE, 0, ok, 0, 1'b1);
        end
        REQ_CHANGE: begin
          if (q.slot < NSLOT && slot_used[q.slot]) begin
            reload[q.slot] = ivl;
            if (int'(ivl) < countdown[q.slot]) countdown[q.slot] = int'(ivl);
            ok = 1'b1;
          end
          push_result(KIND_CHANGE, 0, ok, 0, 1'b1);
        end
        REQ_TICK: begin
          if (q.elapsed != 0) begin
            for (int i = 0; i < NSLOT; i++) begin
              if (slot_used[i]) begin
                diff = longint'(countdown[i]) - longint'(q.elapsed);
                if (diff < CD_FLOOR) diff = CD_FLOOR;
                if (diff < 0) begin
                  countdown[i] = int'(diff + longint'(reload[i]));
                  dispatches++;
                  push_result(KIND_DISPATCH, i, 1'b1, 0, 1'b0);
                end else begin
                  countdown[i] = int'(diff);
                end
              end
            end
          end
          // minimum scan stops at the first expired countdown
          wait_val = int'(wait_cap);
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_used[i]) begin
              if (countdown[i] < wait_val) wait_val = countdown[i];
              if (countdown[i] <= 0) break;
            end
          end
          push_result(KIND_TICK_DONE, 0, 1'b1, wait_val, 1'b1);
        end
        REQ_CLEAR: begin
          clear_table();
          push_result(KIND_CLEARED, 0, 1'b1, 0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, kind %0d slot %0d", $time, got.kind,
                 got.task_slot);
        return;
      end
      want = due_results.pop_front();
      checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("task_slot", want.task_slot, got.task_slot);
      compare_field("ok", want.ok, got.ok);
      compare_field("next_wait", longint'(want.next_wait), longint'(got.next_wait));
      compare_field("active_count", want.active_count, got.active_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [REQ_W-1:0]              in_req_type;
  logic [SLOT_IN_W-1:0]          in_slot;
  logic [IV_W-1:0]               in_interval;
  logic [IV_W-1:0]               in_elapsed;
  logic                          out_strobe;
  logic [KIND_W-1:0]             out_kind;
  logic [$clog2(NSLOT)-1:0]      out_task_slot;
  logic                          out_ok;
  logic signed [CD_W-1:0]        out_next_wait;
  logic [$clog2(NSLOT+1)-1:0]    out_active_count;
  logic                          out_last;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  dispatch_scoreboard sb;
  int cycles;
  int items_sent;

  periodic_task_dispatcher_top #(.NUM_SLOTS(NSLOT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_slot(in_slot), .in_interval(in_interval),
    .in_elapsed(in_elapsed), .out_strobe(out_strobe), .out_kind(out_kind),
    .out_task_slot(out_task_slot), .out_ok(out_ok), .out_next_wait(out_next_wait),
    .out_active_count(out_active_count), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding", $time, cycles,
               sb.due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result('{out_kind, out_task_slot, out_ok, out_next_wait, out_active_count,
                        out_last});
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(logic [REQ_W-1:0] rq, logic [SLOT_IN_W-1:0] sl,
                              logic [IV_W-1:0] iv, logic [IV_W-1:0] el, int idle_pct);
    sched_req_t q;
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      in_req_type = 3'($urandom());
      in_slot = 8'($urandom());
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    q = '{rq, sl, iv, el};
    start = 1'b1;
    in_req_type = rq;
    in_slot = sl;
    in_interval = iv;
    in_elapsed = el;
    do @(posedge clk); while (busy);
    sb.note_request(q);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_request(int idle_pct, output bit counted);
    int pick;
    logic [REQ_W-1:0] rq;
    logic [SLOT_IN_W-1:0] sl;
    logic [IV_W-1:0] iv;
    logic [IV_W-1:0] el;
    pick = $urandom_range(0, 99);
    sl = 8'($urandom_range(0, NSLOT - 1));
    iv = 16'($urandom_range(1, 40));
    el = 16'($urandom_range(1, 30));
    if ($urandom_range(0, 9) == 0) sl = 8'($urandom());
    if ($urandom_range(0, 7) == 0) iv = 16'($urandom());
    if ($urandom_range(0, 9) == 0) el = 16'($urandom());
    if ($urandom_range(0, 15) == 0) el = '0;
    if (pick < 36) rq = REQ_CREATE;
    else if (pick < 52) rq = REQ_DELETE;
    else if (pick < 67) rq = REQ_CHANGE;
    else if (pick < 95) rq = REQ_TICK;
    else if (pick < 97) rq = REQ_CLEAR;
    else rq = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
    // never aim a change at a slot entry that has not been written yet
    if (rq == REQ_CHANGE && sl < NSLOT && !sb.ever_written[sl]) sl = sl | 8'h10;
    send_request(rq, sl, iv, el, idle_pct);
    counted = (rq <= REQ_CLEAR);
  endtask

  task automatic random_phase(int idle_pct, int n_items, bit fill_first);
    int done;
    bit counted;
    done = 0;
    if (fill_first) begin
      repeat (NSLOT + 1) begin
        send_request(REQ_CREATE, 8'($urandom()), 16'($urandom_range(1, 50)), '0, idle_pct);
        done++;
      end
    end
    while (done < n_items) begin
      random_request(idle_pct, counted);
      if (counted) done++;
    end
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write of wait_cap, then read it back.
  task automatic write_wait_cap(logic [15:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = WAIT_CAP_ADDR;
    pwdata = {16'h0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.wait_cap = value;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== value) begin
      sb.errors++;
      $display("%0t: wait_cap readback mismatch, expected %0d, actual %0d", $time, value,
               prdata[15:0]);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    logic [15:0] mid_cap;
    sb = new;
    sb.clear_table();
    sb.wait_cap = WAIT_CAP_RST;
    cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = '0;
    in_slot = '0;
    in_interval = '0;
    in_elapsed = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset value of wait_cap, field extremes, every request and corner case
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'd5, 0);       // empty table
    send_request(REQ_CREATE, 8'hFF, 16'h0000, 16'h0000, 0);  // zero interval taken as one
    send_request(REQ_CREATE, 8'h00, 16'hFFFF, 16'h0000, 0);
    send_request(REQ_CREATE, 8'h00, 16'd10, 16'h0000, 0);
    send_request(REQ_CHANGE, 8'd1, 16'd5, 16'h0000, 0);      // countdown clamped down
    send_request(REQ_CHANGE, 8'd2, 16'd100, 16'h0000, 0);    // countdown kept
    send_request(REQ_CHANGE, 8'd200, 16'd7, 16'h0000, 0);    // out of range
    send_request(REQ_DELETE, 8'hFF, 16'h0000, 16'h0000, 0);
    send_request(REQ_DELETE, 8'd5, 16'h0000, 16'h0000, 0);   // free slot
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 0);    // nothing elapsed
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'd3, 0);
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'hFFFF, 0);    // every slot expires
    send_request(REQ_DELETE, 8'd1, 16'h0000, 16'h0000, 0);
    send_request(REQ_CHANGE, 8'd1, 16'd3, 16'h0000, 0);      // freed slot
    send_request(REQ_CREATE, 8'h00, 16'd2, 16'h0000, 0);     // reuses slot below hint
    for (int c = REQ_RSVD_FIRST; c <= REQ_RSVD_LAST; c++)
      send_request(3'(c), 8'h00, 16'h0000, 16'h0000, 0);
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'd2, 0);
    send_request(REQ_CLEAR, 8'h00, 16'h0000, 16'h0000, 0);
    send_request(REQ_TICK, 8'h00, 16'h0000, 16'd1, 0);
    start = 1'b0;
    wait_drained();

    write_wait_cap(16'd0);
    random_phase(17, 33, 1'b1);
    wait_drained();

    write_wait_cap(16'hFFFF);
    random_phase(54, 33, 1'b0);
    wait_drained();

    mid_cap = 16'($urandom_range(1, 60));
    write_wait_cap(mid_cap);
    random_phase(0, 33, 1'b0);
    wait_drained();

    if (sb.due_results.size() != 0) begin
      sb.errors += sb.due_results.size();
      $display("%0t: %0d result beats never arrived", $time, sb.due_results.size());
    end
    $display("Sent %0d requests, checked %0d result beats (%0d dispatches).", items_sent,
             sb.checked, sb.dispatches);
    $display("wait_cap settings 200, 0, 65535 and %0d; sender idle 17%%, 54%%, 0%%.",
             mid_cap);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
